>>> hw/rtl/filter_table_sample_splat_assert.svh
// assertion macros for the film tile splat block
// expects clk and rst_n in the scope of the user
`ifndef FILTER_TABLE_SAMPLE_SPLAT_ASSERT_SVH
`define FILTER_TABLE_SAMPLE_SPLAT_ASSERT_SVH

// same-cycle implication
`define FTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fts_pkg.sv
// shared types, codes and constants of the film tile splat block
// no dependencies
package fts_pkg;

  localparam int TILE_DIM_DEF    = 32;
  localparam int TABLE_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_SPLAT = 2'd0,
    CMD_DIRECT = 2'd1,
    CMD_READ = 2'd2,
    CMD_TABLE = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [3:0] {
    REG_BMIN_X = 4'd0,
    REG_BMIN_Y = 4'd1,
    REG_BMAX_X = 4'd2,
    REG_BMAX_Y = 4'd3,
    REG_RAD_X  = 4'd4,
    REG_RAD_Y  = 4'd5,
    REG_INV_X  = 4'd6,
    REG_INV_Y  = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [19:0]        sample_x;
    logic [19:0]        sample_y;
    logic [11:0]        pixel_x;
    logic [11:0]        pixel_y;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [7:0]         count;
    logic [7:0]         table_index;
    logic signed [15:0] table_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [47:0] red_sum;
    logic signed [47:0] green_sum;
    logic signed [47:0] blue_sum;
    logic signed [31:0] weight_total;
  } out_t;

  typedef struct packed {
    logic [11:0] bound_min_x;
    logic [11:0] bound_min_y;
    logic [12:0] bound_max_x;
    logic [12:0] bound_max_y;
    logic [10:0] radius_x;
    logic [10:0] radius_y;
    logic [15:0] inv_radius_x;
    logic [15:0] inv_radius_y;
  } cfg_t;

  typedef struct packed {
    logic signed [14:0] lo;
    logic signed [14:0] hi;
  } win_t;

  // one classified request between front and back
  typedef struct packed {
    cmd_t               cmd;
    logic [19:0]        sx;
    logic [19:0]        sy;
    logic [11:0]        px;
    logic [11:0]        py;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [7:0]         count;
    logic [7:0]         tidx;
    logic signed [15:0] tval;
    win_t               wx;
    win_t               wy;
    logic               hit;
  } qent_t;

endpackage

>>> hw/rtl/fts_front.sv
// front part: classifies requests and queues them for the back part
// depends on fts_pkg
module fts_front import fts_pkg::*; #(
  parameter int TILE_DIM = TILE_DIM_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_stall,
  input  in_t   in_data,
  output logic  q_valid,
  output qent_t q_data,
  input  logic  q_pop
);

  function automatic win_t calc_win(input logic [19:0] s, input logic [10:0] r,
                                    input logic [11:0] bmin, input logic [12:0] bmax);
    logic signed [22:0] lo_v;
    logic signed [22:0] hi_v;
    logic signed [14:0] bmin_s;
    logic signed [14:0] tmax;
    win_t w;
    lo_v = $signed({3'b0, s}) - 23'sd128 - $signed({12'b0, r}) + 23'sd255;
    hi_v = $signed({3'b0, s}) - 23'sd128 + $signed({12'b0, r});
    w.lo = $signed(15'(lo_v >>> 8));
    w.hi = $signed(15'(hi_v >>> 8));
    bmin_s = $signed({3'b0, bmin});
    tmax = bmin_s + $signed(15'(TILE_DIM - 1));
    if (w.lo < bmin_s) w.lo = bmin_s;
    if (w.hi > $signed({2'b0, bmax}) - 15'sd1) w.hi = $signed({2'b0, bmax}) - 15'sd1;
    if (w.hi > tmax) w.hi = tmax;
    return w;
  endfunction

  function automatic logic in_tile(input logic [11:0] v, input logic [11:0] bmin,
                                   input logic [12:0] bmax);
    logic [12:0] lv;
    lv = {1'b0, v} - {1'b0, bmin};
    return ({1'b0, v} >= {1'b0, bmin}) && (lv < 13'(TILE_DIM)) && ({1'b0, v} < bmax);
  endfunction

  qent_t       ent;
  qent_t       fifo_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;

  always_comb begin
    ent.cmd   = cmd_t'(in_data.command);
    ent.sx    = in_data.sample_x;
    ent.sy    = in_data.sample_y;
    ent.red   = in_data.red;
    ent.green = in_data.green;
    ent.blue  = in_data.blue;
    ent.count = in_data.count;
    ent.tidx  = in_data.table_index;
    ent.tval  = in_data.table_value;
    ent.wx    = calc_win(in_data.sample_x, cfg.radius_x, cfg.bound_min_x, cfg.bound_max_x);
    ent.wy    = calc_win(in_data.sample_y, cfg.radius_y, cfg.bound_min_y, cfg.bound_max_y);
    if (ent.cmd == CMD_DIRECT) begin
      ent.px = in_data.sample_x[19:8];
      ent.py = in_data.sample_y[19:8];
    end else begin
      ent.px = in_data.pixel_x;
      ent.py = in_data.pixel_y;
    end
    if (ent.cmd == CMD_SPLAT) begin
      ent.hit = (ent.wx.lo <= ent.wx.hi) && (ent.wy.lo <= ent.wy.hi);
    end else begin
      ent.hit = in_tile(ent.px, cfg.bound_min_x, cfg.bound_max_x) &&
                in_tile(ent.py, cfg.bound_min_y, cfg.bound_max_y);
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> hw/rtl/fts_back.sv
// back part: clearing pass, splat sequencer, accumulator and table memories
// depends on fts_pkg and filter_table_sample_splat_assert.svh
`include "filter_table_sample_splat_assert.svh"
module fts_back import fts_pkg::*; #(
  parameter int TILE_DIM    = TILE_DIM_DEF,
  parameter int TABLE_WIDTH = TABLE_WIDTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  qent_t q_data,
  output logic  q_pop,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  localparam int CELLS = TILE_DIM * TILE_DIM;
  localparam int CW    = $clog2(CELLS);
  localparam int TWB   = $clog2(TABLE_WIDTH);

  typedef struct packed {
    logic signed [47:0] r;
    logic signed [47:0] g;
    logic signed [47:0] b;
    logic signed [31:0] w;
  } cell_t;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_ROWM  = 10'b0000000100,
    S_ROWQ  = 10'b0000001000,
    S_PXM   = 10'b0000010000,
    S_PXT   = 10'b0000100000,
    S_ACC   = 10'b0001000000,
    S_WR    = 10'b0010000000,
    S_RDOUT = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  function automatic logic [CW-1:0] cell_of(input logic [11:0] x, input logic [11:0] y,
                                             input logic [11:0] bx, input logic [11:0] by);
    logic [11:0] lx;
    logic [11:0] ly;
    lx = x - bx;
    ly = y - by;
    return CW'(ly) * CW'(TILE_DIM) + CW'(lx);
  endfunction

  function automatic logic [48:0] sat48(input logic signed [47:0] a,
                                        input logic signed [32:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + 49'(b);
    if (s > 49'sh7FFFFFFFFFFF) return {1'b1, 48'h7FFFFFFFFFFF};
    if (s < -49'sh800000000000) return {1'b1, 48'h800000000000};
    return {1'b0, s[47:0]};
  endfunction

  function automatic logic [32:0] sat32(input logic signed [31:0] a,
                                        input logic signed [22:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + 33'(b);
    if (s > 33'sh7FFFFFFF) return {1'b1, 32'h7FFFFFFF};
    if (s < -33'sh80000000) return {1'b1, 32'h80000000};
    return {1'b0, s[31:0]};
  endfunction

  state_t             state_r, state_nxt;
  logic [CW-1:0]      clr_cnt_r;
  qent_t              cur_r;
  logic signed [14:0] x_r, y_r;
  logic [38:0]        dprod_r;
  logic [TWB-1:0]     iy_r;
  logic signed [15:0] tw_r;
  logic signed [32:0] pr_r, pg_r, pb_r;
  logic signed [22:0] pw_r;
  logic               sat_r;
  logic [CW-1:0]      cell_r;
  out_t               res_r;
  out_t               out_r;
  logic               out_valid_r;

  logic signed [15:0] tbl [256];
  cell_t              mem [CELLS];
  cell_t              rdata_r;

  // distance to table coordinate
  logic signed [14:0] cp;
  logic [19:0]        cs;
  logic [15:0]        cinv;
  logic signed [23:0] dvec;
  logic [22:0]        adist;
  logic [45:0]        qfull;
  logic [23:0]        qv;
  logic [TWB-1:0]     qc;
  logic [7:0]         toff;
  logic [CW-1:0]      pix_cell;
  logic               done_take;
  logic [48:0]        nr, ng, nb;
  logic [32:0]        nw;
  logic               mem_re;
  logic [CW-1:0]      mem_ra;

  always_comb begin
    if (state_r == S_ROWM) begin
      cp = y_r; cs = cur_r.sy; cinv = cfg.inv_radius_y;
    end else begin
      cp = x_r; cs = cur_r.sx; cinv = cfg.inv_radius_x;
    end
    dvec  = $signed({cp, 8'b0}) + 24'sd128 - $signed({4'b0, cs});
    adist = dvec[23] ? 23'(-dvec) : 23'(dvec);
    qfull = 46'(dprod_r) * 46'(TABLE_WIDTH);
    qv    = qfull[45:22];
    qc    = (qv > 24'(TABLE_WIDTH - 1)) ? TWB'(TABLE_WIDTH - 1) : TWB'(qv);
    toff  = 8'(12'(iy_r) * 12'(TABLE_WIDTH) + 12'(qc));
    pix_cell = cell_of(x_r[11:0], y_r[11:0], cfg.bound_min_x, cfg.bound_min_y);
    nr = sat48(rdata_r.r, pr_r);
    ng = sat48(rdata_r.g, pg_r);
    nb = sat48(rdata_r.b, pb_r);
    nw = sat32(rdata_r.w, pw_r);
    done_take = !out_valid_r || !out_stall;
  end

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    mem_re = 1'b0;
    mem_ra = pix_cell;
    if (state_r == S_IDLE && q_valid && q_data.hit &&
        (q_data.cmd == CMD_DIRECT || q_data.cmd == CMD_READ)) begin
      mem_re = 1'b1;
      mem_ra = cell_of(q_data.px, q_data.py, cfg.bound_min_x, cfg.bound_min_y);
    end else if (state_r == S_PXT) begin
      mem_re = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == CW'(CELLS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (q_valid) begin
          case (q_data.cmd)
            CMD_SPLAT:  state_nxt = q_data.hit ? S_ROWM : S_DONE;
            CMD_DIRECT: state_nxt = q_data.hit ? S_ACC : S_DONE;
            CMD_READ:   state_nxt = q_data.hit ? S_RDOUT : S_DONE;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_ROWM:  state_nxt = S_ROWQ;
      S_ROWQ:  state_nxt = S_PXM;
      S_PXM:   state_nxt = S_PXT;
      S_PXT:   state_nxt = S_ACC;
      S_ACC:   state_nxt = S_WR;
      S_WR: begin
        if (cur_r.cmd != CMD_SPLAT) state_nxt = S_DONE;
        else if (x_r != cur_r.wx.hi) state_nxt = S_PXM;
        else if (y_r != cur_r.wy.hi) state_nxt = S_ROWM;
        else state_nxt = S_DONE;
      end
      S_RDOUT: state_nxt = S_DONE;
      S_DONE:  if (done_take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + CW'(1);
      if (state_r == S_DONE && done_take) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid && q_data.cmd == CMD_TABLE) tbl[q_data.tidx] <= q_data.tval;
    if (state_r == S_PXT) tw_r <= tbl[toff];
  end

  // accumulator memory
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) mem[clr_cnt_r] <= '0;
    else if (state_r == S_WR)
      mem[cell_r] <= '{r: nr[47:0], g: ng[47:0], b: nb[47:0], w: nw[31:0]};
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (mem_re) cell_r <= mem_ra;
    if (state_r == S_DONE && done_take) out_r <= res_r;
    unique case (state_r)
      S_IDLE: begin
        cur_r <= q_data;
        x_r   <= q_data.wx.lo;
        y_r   <= q_data.wy.lo;
        sat_r <= 1'b0;
        res_r <= '{status: (q_data.cmd != CMD_TABLE && !q_data.hit) ? ST_NONE : ST_DONE,
                   default: '0};
      end
      S_ROWM, S_PXM: dprod_r <= 39'(adist) * 39'(cinv);
      S_ROWQ: iy_r <= qc;
      S_ACC: begin
        if (cur_r.cmd == CMD_SPLAT) begin
          pr_r <= $signed({1'b0, cur_r.red}) * tw_r;
          pg_r <= $signed({1'b0, cur_r.green}) * tw_r;
          pb_r <= $signed({1'b0, cur_r.blue}) * tw_r;
          pw_r <= 23'(tw_r);
        end else begin
          pr_r <= $signed({1'b0, cur_r.red}) * 16'sd16384;
          pg_r <= $signed({1'b0, cur_r.green}) * 16'sd16384;
          pb_r <= $signed({1'b0, cur_r.blue}) * 16'sd16384;
          pw_r <= $signed({1'b0, cur_r.count, 14'b0});
        end
      end
      S_WR: begin
        if (nr[48] || ng[48] || nb[48] || nw[32]) begin
          sat_r <= 1'b1;
          res_r.status <= ST_SAT;
        end
        if (x_r != cur_r.wx.hi) begin
          x_r <= x_r + 15'sd1;
        end else begin
          x_r <= cur_r.wx.lo;
          y_r <= y_r + 15'sd1;
        end
      end
      S_RDOUT: begin
        res_r <= '{status: res_r.status, red_sum: rdata_r.r, green_sum: rdata_r.g,
                   blue_sum: rdata_r.b, weight_total: rdata_r.w};
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `FTS_ASSERT_NOW(a_no_pop_clear, state_r == S_CLEAR, !q_pop, "request taken during clear pass")
  `FTS_ASSERT_NOW(a_x_in_win, state_r == S_PXM, x_r >= cur_r.wx.lo && x_r <= cur_r.wx.hi,
    "column outside window")
  `FTS_ASSERT_NEXT(a_wr_after_acc, state_r == S_ACC, state_r == S_WR,
    "write does not follow accumulate")
  `FTS_ASSERT_NOW(a_sat_status, sat_r && state_r == S_DONE, res_r.status == ST_SAT,
    "saturation not reported")

endmodule

>>> hw/rtl/filter_table_sample_splat.sv
// film tile splat accumulator: each request from the queue head is a table write,
// a read of one tile cell, a direct add to one cell, or a splat that walks the rows
// and columns of its window, with a read-modify-write of the tile memory for each
// touched pixel. two requests may wait in the queue while the back part works; one result
// register decouples the result side. after reset all TILE_DIM*TILE_DIM cells of the tile
// memory are cleared before the first request runs; config takes effect at once
module filter_table_sample_splat import fts_pkg::*; #(
  parameter int TILE_DIM    = TILE_DIM_DEF,
  parameter int TABLE_WIDTH = TABLE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg_r;
  logic  q_valid;
  qent_t q_data;
  logic  q_pop;

  // config writes are always accepted and registered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bound_min_x  <= 12'd0;
      cfg_r.bound_min_y  <= 12'd0;
      cfg_r.bound_max_x  <= 13'd32;
      cfg_r.bound_max_y  <= 13'd32;
      cfg_r.radius_x     <= 11'd256;
      cfg_r.radius_y     <= 11'd256;
      cfg_r.inv_radius_x <= 16'd16384;
      cfg_r.inv_radius_y <= 16'd16384;
    end else if (cfg_valid) begin
      // unknown register indexes are dropped
      unique case (cfg_index)
        REG_BMIN_X: cfg_r.bound_min_x  <= cfg_data[11:0];
        REG_BMIN_Y: cfg_r.bound_min_y  <= cfg_data[11:0];
        REG_BMAX_X: cfg_r.bound_max_x  <= cfg_data[12:0];
        REG_BMAX_Y: cfg_r.bound_max_y  <= cfg_data[12:0];
        REG_RAD_X:  cfg_r.radius_x     <= cfg_data[10:0];
        REG_RAD_Y:  cfg_r.radius_y     <= cfg_data[10:0];
        REG_INV_X:  cfg_r.inv_radius_x <= cfg_data;
        REG_INV_Y:  cfg_r.inv_radius_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: window clipping and tile hit test, then the request queue
  fts_front #(.TILE_DIM(TILE_DIM)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  // back: clearing pass, table writes, per-pixel weight lookup, saturating accumulation and reads
  fts_back #(.TILE_DIM(TILE_DIM), .TABLE_WIDTH(TABLE_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
